// ----- design/mspq_pkg.sv -----
// Package for the multilevel sorted priority queue.
// Holds shared types, status and command codes and parameter defaults.
// No dependencies.
package mspq_pkg;

   localparam int LEVELS_DEF = 8;
   localparam int DEPTH_DEF  = 16;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_SERVE  = 1'b1;

   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_SERVED   = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   typedef struct packed {
      logic [31:0] key;
      logic [15:0] id;
   } entry_type;

   typedef struct packed {
      logic        write;
      logic        serve;
      logic [31:0] key;
      logic [15:0] id;
   } cell_ctl_type;

endpackage

// ----- design/mspq_cell.sv -----
// One slot position of the queue chain, holding that slot for every level.
// Depends on mspq_pkg.
module mspq_cell #(
   parameter int LEVELS = mspq_pkg::LEVELS_DEF
) (
   input  logic                        clock,
   input  logic [$clog2(LEVELS)-1:0]   lvl_idx,
   input  mspq_pkg::cell_ctl_type      ctl,
   input  logic                        occupied,
   input  logic                        prev_le,
   input  mspq_pkg::entry_type         prev_entry,
   input  mspq_pkg::entry_type         next_entry,
   output mspq_pkg::entry_type         entry,
   output logic                        le
);
   import mspq_pkg::*;

   entry_type store_ff [LEVELS];
   entry_type entry_in;

   assign entry = store_ff[lvl_idx];
   assign le    = occupied && ($signed(entry.key) <= $signed(ctl.key));

   // An insert keeps entries at or below the new key, drops the new item into
   // the first slot past them and moves everything later up by one.
   always_comb begin
      if (ctl.serve) begin
         entry_in = next_entry;
      end else if (le) begin
         entry_in = entry;
      end else if (prev_le) begin
         entry_in = '{key: ctl.key, id: ctl.id};
      end else begin
         entry_in = prev_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.write) begin
         store_ff[lvl_idx] <= entry_in;
      end
   end

endmodule

// ----- design/multilevel_sorted_priority_queue_unit.sv -----
// Multilevel sorted priority queue: LEVELS sorted queues of DEPTH entries.
// An accepted item is registered and raises busy; while busy is high the whole cell
// row of the selected level is read, shifted and written, and the result is
// registered. The result strobe is busy delayed by a register, so it rises together
// with the result. A new item is taken only once busy has fallen again.
// Reset clears the level counts at once; entries are not cleared and need no
// clearing pass. The receiver cannot stall, so results never back up.
module multilevel_sorted_priority_queue_unit #(
   parameter int LEVELS = mspq_pkg::LEVELS_DEF,
   parameter int DEPTH  = mspq_pkg::DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [2:0]  req_level,
   input  logic [15:0] req_event_id,
   input  logic [31:0] req_event_key,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_served_id,
   output logic [31:0] rsp_served_key,
   output logic [2:0]  rsp_served_level
);
   import mspq_pkg::*;

   localparam int LW = $clog2(LEVELS);
   localparam int CW = $clog2(DEPTH + 1);

   logic            busy_ff;
   logic            cmd_ff;
   logic [2:0]      level_ff;
   logic [15:0]     id_ff;
   logic [31:0]     key_ff;
   logic [CW-1:0]   counts_ff [LEVELS];

   logic            rsp_valid_ff;
   logic [1:0]      status_ff, status_in;
   logic [15:0]     sid_ff, sid_in;
   logic [31:0]     skey_ff, skey_in;
   logic [2:0]      slvl_ff, slvl_in;

   logic            found;
   logic [LW-1:0]   top_idx;
   logic            level_ok;
   logic [LW-1:0]   exec_idx;
   logic [CW-1:0]   cnt_sel;
   logic            full;
   logic            do_write;
   cell_ctl_type    ctl;

   entry_type       entries [DEPTH];
   logic            les     [DEPTH];
   logic            occ     [DEPTH];

   assign busy = busy_ff;

   // Highest-numbered non-empty level; the last hit in the scan wins.
   always_comb begin
      found   = 1'b0;
      top_idx = '0;
      for (int i = 0; i < LEVELS; i++) begin
         if (counts_ff[i] != '0) begin
            found   = 1'b1;
            top_idx = LW'(i);
         end
      end
   end

   assign level_ok = 32'(level_ff) < LEVELS;
   assign exec_idx = (cmd_ff == CMD_SERVE) ? top_idx : (level_ok ? LW'(level_ff) : '0);
   assign cnt_sel  = counts_ff[exec_idx];
   assign full     = cnt_sel == CW'(DEPTH);
   assign do_write = busy_ff && ((cmd_ff == CMD_SERVE) ? found : (level_ok && !full));

   assign ctl = '{write: do_write, serve: cmd_ff == CMD_SERVE, key: key_ff, id: id_ff};

   for (genvar j = 0; j < DEPTH; j++) begin : g_cell
      assign occ[j] = CW'(j) < cnt_sel;
      mspq_cell #(.LEVELS(LEVELS)) u_cell (
         .clock      (clock),
         .lvl_idx    (exec_idx),
         .ctl        (ctl),
         .occupied   (occ[j]),
         .prev_le    ((j == 0) ? 1'b1 : les[(j == 0) ? 0 : j - 1]),
         .prev_entry (entries[(j == 0) ? 0 : j - 1]),
         .next_entry (entries[(j == DEPTH - 1) ? j : j + 1]),
         .entry      (entries[j]),
         .le         (les[j])
      );
   end

   always_comb begin
      status_in = ST_INSERTED;
      sid_in    = '0;
      skey_in   = '0;
      slvl_in   = '0;
      if (cmd_ff == CMD_SERVE) begin
         if (found) begin
            status_in = ST_SERVED;
            sid_in    = entries[0].id;
            skey_in   = entries[0].key;
            slvl_in   = 3'(top_idx);
         end else begin
            status_in = ST_EMPTY;
         end
      end else if (!level_ok || full) begin
         status_in = ST_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LEVELS; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= busy_ff;
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
         end else begin
            busy_ff <= 1'b0;
         end
         if (do_write) begin
            if (cmd_ff == CMD_SERVE) begin
               counts_ff[exec_idx] <= cnt_sel - CW'(1);
            end else begin
               counts_ff[exec_idx] <= cnt_sel + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         cmd_ff   <= req_cmd;
         level_ff <= req_level;
         id_ff    <= req_event_id;
         key_ff   <= req_event_key;
      end
      if (busy_ff) begin
         status_ff <= status_in;
         sid_ff    <= sid_in;
         skey_ff   <= skey_in;
         slvl_ff   <= slvl_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_served_id    = sid_ff;
   assign rsp_served_key   = skey_ff;
   assign rsp_served_level = slvl_ff;

endmodule

// ----- design/mspq_checker.sv -----
// Port-level checks for the multilevel sorted priority queue, bound to the top.
// Depends on mspq_pkg and multilevel_sorted_priority_queue_unit.
module mspq_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_served_id,
   input logic [31:0] rsp_served_key,
   input logic [2:0]  rsp_served_level
);
   import mspq_pkg::*;

   // Every accepted item is followed by its result.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##2 rsp_valid)
      else $error("result missing two cycles after an accepted item");

   // No result appears without an item accepted before it.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without an accepted item");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accept");

   // Only a served item carries payload.
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_SERVED |->
         rsp_served_id == '0 && rsp_served_key == '0 && rsp_served_level == '0)
      else $error("nonzero payload on a result that served nothing");

endmodule

bind multilevel_sorted_priority_queue_unit mspq_checker u_mspq_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_status       (rsp_status),
   .rsp_served_id    (rsp_served_id),
   .rsp_served_key   (rsp_served_key),
   .rsp_served_level (rsp_served_level)
);
